// File: sv/esgd_pkg.sv
// Shared constants, widths and codes of the embedding table SGD engine.
package esgd_pkg;

  // Fixed field widths
  localparam int DATA_W      = 32;
  localparam int LR_W        = 17;
  localparam int VC_W        = 11;
  localparam int CMD_W       = 2;
  localparam int POS_W       = 8;
  localparam int ELEM_W      = 4;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  // Default sizing of the tables
  localparam int VOCAB_DEF      = 1024;
  localparam int DIM_DEF        = 16;
  localparam int MAX_TOKENS_DEF = 256;

  // Register reset values
  localparam logic [LR_W-1:0] LR_RESET = 17'd655;
  localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

  // Register indexes
  localparam logic CFG_LR = 1'b0;
  localparam logic CFG_VC = 1'b1;

  // Result kinds
  localparam logic KIND_EMBED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_GRAD   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_e;

endpackage

// File: sv/esgd_ram.sv
// Generic single-port RAM with registered read data.
module esgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/esgd_alu.sv
// Shared arithmetic unit: saturating gradient add and two-stage SGD step.
module esgd_alu import esgd_pkg::*; (
  input  logic              clk_i,
  input  logic              mul_en_i,
  input  logic [DATA_W-1:0] add_a_i,
  input  logic [DATA_W-1:0] add_b_i,
  input  logic [DATA_W-1:0] grad_i,
  input  logic [DATA_W-1:0] weight_i,
  input  logic [LR_W-1:0]   lr_i,
  output logic [DATA_W-1:0] sum_o,
  output logic [DATA_W-1:0] upd_o
);

  localparam int PROD_W = DATA_W + LR_W;
  localparam int DIFF_W = DATA_W + 3;

  logic [DATA_W:0]   sum_c;
  logic [DATA_W-1:0] mag_c;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  logic [DATA_W-1:0] w_q;
  logic [DIFF_W-1:0] wx_c;
  logic [DIFF_W-1:0] px_c;
  logic [DIFF_W-1:0] diff_c;

  // Saturating add of two signed words
  always_comb begin
    sum_c = {add_a_i[DATA_W-1], add_a_i} + {add_b_i[DATA_W-1], add_b_i};
    if (sum_c[DATA_W] != sum_c[DATA_W-1]) begin
      sum_o = sum_c[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_o = sum_c[DATA_W-1:0];
    end
  end

  // Stage 1: |dW| * lr, sign and weight kept beside it
  assign mag_c = grad_i[DATA_W-1] ? (~grad_i + DATA_W'(1)) : grad_i;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= PROD_W'(mag_c) * PROD_W'(lr_i);
      neg_q  <= grad_i[DATA_W-1];
      w_q    <= weight_i;
    end
  end

  // Stage 2: drop 16 fraction bits (toward zero), subtract, saturate
  always_comb begin
    wx_c   = {{3{w_q[DATA_W-1]}}, w_q};
    px_c   = DIFF_W'(prod_q[PROD_W-1:16]);
    diff_c = neg_q ? (wx_c + px_c) : (wx_c - px_c);
    if (!diff_c[DIFF_W-1] && (|diff_c[DIFF_W-2:DATA_W-1])) begin
      upd_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (diff_c[DIFF_W-1] && !(&diff_c[DIFF_W-2:DATA_W-1])) begin
      upd_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      upd_o = diff_c[DATA_W-1:0];
    end
  end

endmodule

// File: sv/embedding_table_sgd_engine_core.sv
// Embedding table with SGD update: sequencer, tables and stream ports.
//
// Embedding lookup engine with in-place SGD, signed Q16.16. One item is
// worked at a time and s_axis_tready_o is low until it is done; the last
// result may still wait in the output register while the next item enters.
// Per item, with the result side ready: a load writes one weight; a gradient
// fetches the recorded id, reads the entry and writes the sum, or is dropped
// when the element is at or beyond DIM; a lookup does one single-port weight
// read and one output beat per element; an update walks rows*DIM entries,
// rows being vocab_count limited to 1..VOCAB, with read, multiply and
// write-back per entry through the one shared multiply/saturate unit on the
// single-port weight and gradient memories, then gives a done beat. A full
// output register adds its wait to each lookup element and to the done beat
// of an update. After reset all VOCAB*DIM gradient entries are zeroed by a
// clearing pass that accepts no item; configuration writes are always taken.
module embedding_table_sgd_engine_core import esgd_pkg::*; #(
  parameter int VOCAB      = VOCAB_DEF,
  parameter int DIM        = DIM_DEF,
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Item stream in
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [7:0] position, [39:8] token_id, [43:40] element, [75:44] value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] cmd
  input  logic [CMD_W-1:0]       s_axis_tuser_i,
  // Result stream out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [3:0] out_element, [35:4] out_value
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] out_kind
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [LR_W-1:0]        cfg_data_i
);

  localparam int ENTRIES = VOCAB * DIM;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int ID_W    = $clog2(VOCAB);
  localparam int ROW_W   = $clog2(VOCAB + 1);
  localparam int SLOT_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int CNT_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ST_W    = 4;

  // Sequencer states
  localparam logic [ST_W-1:0] S_CLEAR   = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd1;
  localparam logic [ST_W-1:0] S_LK_RD   = 4'd2;
  localparam logic [ST_W-1:0] S_LK_WAIT = 4'd3;
  localparam logic [ST_W-1:0] S_GR_ID   = 4'd4;
  localparam logic [ST_W-1:0] S_GR_RD   = 4'd5;
  localparam logic [ST_W-1:0] S_GR_WR   = 4'd6;
  localparam logic [ST_W-1:0] S_LD      = 4'd7;
  localparam logic [ST_W-1:0] S_UP_RD   = 4'd8;
  localparam logic [ST_W-1:0] S_UP_MUL  = 4'd9;
  localparam logic [ST_W-1:0] S_UP_WR   = 4'd10;
  localparam logic [ST_W-1:0] S_UP_DONE = 4'd11;

  // Input beat fields
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_tok;
  logic [ELEM_W-1:0] in_elem;
  logic [DATA_W-1:0] in_val;
  cmd_e              in_cmd;
  logic              s_acc;
  logic              in_elem_ok;

  assign in_pos  = s_axis_tdata_i[7:0];
  assign in_tok  = s_axis_tdata_i[39:8];
  assign in_elem = s_axis_tdata_i[43:40];
  assign in_val  = s_axis_tdata_i[75:44];
  assign in_cmd  = cmd_e'(s_axis_tuser_i);
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_elem_ok = 32'(in_elem) < 32'(DIM);

  // Registers
  logic [ST_W-1:0]   state_q, state_d;
  logic [ADDR_W-1:0] walk_q, walk_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [ELEM_W-1:0] elem_q, elem_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LR_W-1:0]   lr_q;
  logic [VC_W-1:0]   vocab_q;
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [ELEM_W-1:0] out_elem_q, out_elem_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic              out_last_q, out_last_d;

  // Memory and unit hookup
  logic              w_we, g_we, p_we, mul_en;
  logic [ADDR_W-1:0] addr_c, w_addr, g_addr;
  logic [DATA_W-1:0] w_wdata, g_wdata, w_rdata, g_rdata;
  logic [ID_W-1:0]   pid_rdata;
  logic [DATA_W-1:0] sum_c, upd_c;

  logic [ROW_W-1:0]  rows_c;
  logic [ID_W-1:0]   rows_m1_c;
  logic [ID_W-1:0]   tok_id_c;
  logic [ID_W-1:0]   pid_clamp_c;
  logic [POS_W-1:0]  rem_c;
  logic [SLOT_W-1:0] slot_c;
  logic              out_free;
  logic              lk_last;

  // Rows in use: vocab_count limited to 1..VOCAB
  always_comb begin
    if (vocab_q == '0) begin
      rows_c = ROW_W'(1);
    end else if (32'(vocab_q) > 32'(VOCAB)) begin
      rows_c = ROW_W'(VOCAB);
    end else begin
      rows_c = ROW_W'(vocab_q);
    end
  end

  assign rows_m1_c = ID_W'(rows_c - ROW_W'(1));

  // Clamp raw token id into the rows in use
  always_comb begin
    if (in_tok[DATA_W-1]) begin
      tok_id_c = '0;
    end else if ({1'b0, in_tok} >= 33'(rows_c)) begin
      tok_id_c = rows_m1_c;
    end else begin
      tok_id_c = ID_W'(in_tok);
    end
  end

  // Recorded id is clamped again against the current row count
  assign pid_clamp_c = (ROW_W'(pid_rdata) >= rows_c) ? rows_m1_c : pid_rdata;

  // Position modulo MAX_TOKENS by restoring subtraction
  always_comb begin
    rem_c = in_pos;
    for (int k = POS_W - 1; k >= 0; k--) begin
      if (32'(rem_c) >= (32'(MAX_TOKENS) << k)) begin
        rem_c = rem_c - POS_W'(32'(MAX_TOKENS) << k);
      end
    end
  end

  assign slot_c = SLOT_W'(rem_c);

  // Entry address: row * DIM + element
  assign addr_c = ADDR_W'(32'(id_q) * 32'(DIM))
                + ((state_q == S_LK_RD) ? ADDR_W'(cnt_q) : ADDR_W'(elem_q));

  assign w_addr = ((state_q == S_UP_RD) || (state_q == S_UP_MUL) || (state_q == S_UP_WR))
                ? walk_q : addr_c;
  assign g_addr = ((state_q == S_CLEAR) || (state_q == S_UP_RD) || (state_q == S_UP_MUL) ||
                   (state_q == S_UP_WR)) ? walk_q : addr_c;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign lk_last  = (cnt_q == CNT_W'(DIM - 1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    last_d      = last_q;
    id_d        = id_q;
    elem_d      = elem_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_elem_d  = out_elem_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    w_we        = 1'b0;
    w_wdata     = val_q;
    g_we        = 1'b0;
    g_wdata     = '0;
    p_we        = 1'b0;
    mul_en      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        g_we   = 1'b1;
        walk_d = walk_q + ADDR_W'(1);
        if (walk_q == ADDR_W'(ENTRIES - 1)) begin
          walk_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          id_d   = tok_id_c;
          elem_d = in_elem;
          val_d  = in_val;
          cnt_d  = '0;
          case (in_cmd)
            CMD_LOOKUP: begin
              p_we    = 1'b1;
              state_d = S_LK_RD;
            end
            CMD_GRAD:   state_d = in_elem_ok ? S_GR_ID : S_IDLE;
            CMD_UPDATE: begin
              last_d  = ADDR_W'(32'(rows_c) * 32'(DIM) - 32'd1);
              state_d = S_UP_RD;
            end
            CMD_LOAD:   state_d = in_elem_ok ? S_LD : S_IDLE;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      // Lookup: one weight read, then one output beat per element
      S_LK_RD: begin
        if (out_free) begin
          state_d = S_LK_WAIT;
        end
      end
      S_LK_WAIT: begin
        out_valid_d = 1'b1;
        out_kind_d  = KIND_EMBED;
        out_elem_d  = ELEM_W'(cnt_q);
        out_val_d   = w_rdata;
        out_last_d  = lk_last;
        if (lk_last) begin
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_LK_RD;
        end
      end
      // Gradient: fetch recorded id, read entry, write saturated sum
      S_GR_ID: begin
        id_d    = pid_clamp_c;
        state_d = S_GR_RD;
      end
      S_GR_RD: state_d = S_GR_WR;
      S_GR_WR: begin
        g_we    = 1'b1;
        g_wdata = sum_c;
        state_d = S_IDLE;
      end
      S_LD: begin
        w_we    = 1'b1;
        state_d = S_IDLE;
      end
      // Update walk: read, multiply, write back and clear gradient
      S_UP_RD:  state_d = S_UP_MUL;
      S_UP_MUL: begin
        mul_en  = 1'b1;
        state_d = S_UP_WR;
      end
      S_UP_WR: begin
        w_we    = 1'b1;
        w_wdata = upd_c;
        g_we    = 1'b1;
        if (walk_q == last_q) begin
          walk_d  = '0;
          state_d = S_UP_DONE;
        end else begin
          walk_d  = walk_q + ADDR_W'(1);
          state_d = S_UP_RD;
        end
      end
      S_UP_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DONE;
          out_elem_d  = '0;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      lr_q        <= LR_RESET;
      vocab_q     <= VC_RESET;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LR:  lr_q    <= cfg_data_i;
          CFG_VC:  vocab_q <= cfg_data_i[VC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    id_q       <= id_d;
    elem_q     <= elem_d;
    val_q      <= val_d;
    cnt_q      <= cnt_d;
    out_kind_q <= out_kind_d;
    out_elem_q <= out_elem_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // Tables
  esgd_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .addr_i  (w_addr),
    .wdata_i (w_wdata),
    .rdata_o (w_rdata)
  );

  esgd_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .addr_i  (g_addr),
    .wdata_i (g_wdata),
    .rdata_o (g_rdata)
  );

  esgd_ram #(.WIDTH(ID_W), .DEPTH(MAX_TOKENS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .addr_i  (slot_c),
    .wdata_i (tok_id_c),
    .rdata_o (pid_rdata)
  );

  // Shared arithmetic unit
  esgd_alu u_alu (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .add_a_i  (g_rdata),
    .add_b_i  (val_q),
    .grad_i   (g_rdata),
    .weight_i (w_rdata),
    .lr_i     (lr_q),
    .sum_o    (sum_c),
    .upd_o    (upd_c)
  );

  // Ports
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_val_q, out_elem_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  a_walk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (walk_q == '0))
    else $error("walk index not zero while idle");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_DONE)) |-> m_axis_tlast_o)
    else $error("done result without last");

  a_grad_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_we |-> ((state_q == S_CLEAR) || (state_q == S_GR_WR) || (state_q == S_UP_WR)))
    else $error("gradient write outside its states");

  a_lookup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_cmd == CMD_LOOKUP)) |=> ((state_q == S_LK_RD) && (cnt_q == '0)))
    else $error("lookup did not start at element zero");

endmodule

// File: dv/embed_table_mirror_pkg.sv
// Scoreboard class: mirror of the embedding and gradient tables plus result checker.
package embed_table_mirror_pkg;
  import esgd_pkg::*;

  localparam int ROWS  = VOCAB_DEF;
  localparam int DIM   = DIM_DEF;
  localparam int SLOTS = MAX_TOKENS_DEF;
  localparam int CELLS = ROWS * DIM;

  // One result beat as seen on the master side
  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] elem;
    logic [DATA_W-1:0] val;
    logic              last;
  } beat_t;

  class embed_table_mirror;
    int              weights [CELLS];
    int              grads [CELLS];
    int              slot_row [SLOTS];
    logic [LR_W-1:0] step_size;
    logic [VC_W-1:0] row_limit;
    beat_t           pending_beats[$];
    int unsigned     mismatch_count;
    int unsigned     beats_seen;
    int unsigned     cmd_seen [4];

    function new();
      foreach (weights[i]) weights[i] = 0;
      foreach (grads[i]) grads[i] = 0;
      foreach (slot_row[i]) slot_row[i] = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      step_size      = LR_RESET;
      row_limit      = VC_RESET;
      mismatch_count = 0;
      beats_seen     = 0;
    endfunction

    // Row count actually walked: zero acts as one, oversize acts as full table
    function int rows_active();
      if (row_limit == 0) return 1;
      if (int'(row_limit) > ROWS) return ROWS;
      return int'(row_limit);
    endfunction

    function int clamp_row(longint id);
      int n;
      n = rows_active();
      if (id < 0) return 0;
      if (id >= longint'(n)) return n - 1;
      return int'(id);
    endfunction

    function int sat_word(longint x);
      if (x > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
      if (x < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
      return int'(x);
    endfunction

    function void set_reg(logic idx, logic [LR_W-1:0] data);
      if (idx == CFG_LR) step_size = data;
      else row_limit = data[VC_W-1:0];
    endfunction

    // Apply one accepted item to the mirror and queue the beats it causes
    function void absorb_item(cmd_e cmd, logic [POS_W-1:0] pos, logic [DATA_W-1:0] tok,
                              logic [ELEM_W-1:0] elem, logic [DATA_W-1:0] val);
      int     row;
      int     idx;
      longint g;
      longint mag;
      longint p;
      beat_t  b;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_LOOKUP: begin
          row = clamp_row(longint'($signed(tok)));
          slot_row[int'(pos) % SLOTS] = row;
          for (int d = 0; d < DIM; d++) begin
            b.kind = KIND_EMBED;
            b.elem = ELEM_W'(d);
            b.val  = weights[row * DIM + d];
            b.last = (d == DIM - 1);
            pending_beats.push_back(b);
          end
        end
        CMD_GRAD: begin
          // recorded id is clamped again against the current row count
          row = clamp_row(longint'(slot_row[int'(pos) % SLOTS]));
          if (int'(elem) < DIM) begin
            idx = row * DIM + int'(elem);
            grads[idx] = sat_word(longint'(grads[idx]) + longint'($signed(val)));
          end
        end
        CMD_UPDATE: begin
          for (int i = 0; i < rows_active() * DIM; i++) begin
            g   = longint'(grads[i]);
            mag = (g < 0 ? -g : g) * longint'(step_size);
            p   = mag >>> 16;
            if (g < 0) p = -p;
            weights[i] = sat_word(longint'(weights[i]) - p);
            grads[i]   = 0;
          end
          b.kind = KIND_DONE;
          b.elem = '0;
          b.val  = '0;
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
        default: begin
          row = clamp_row(longint'($signed(tok)));
          if (int'(elem) < DIM) weights[row * DIM + int'(elem)] = int'(val);
        end
      endcase
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at beat %0d: %s", beats_seen, what);
      mismatch_count++;
    endtask

    // Compare one accepted result beat with the oldest expectation
    task check_beat(beat_t got);
      beat_t want;
      string fields;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d elem %0d value %08h last %0d",
                                got.kind, got.elem, got.val, got.last));
      end else begin
        want   = pending_beats.pop_front();
        fields = "";
        if (got.kind !== want.kind) fields = {fields, " kind"};
        if (got.elem !== want.elem) fields = {fields, " element"};
        if (got.val !== want.val) fields = {fields, " value"};
        if (got.last !== want.last) fields = {fields, " last"};
        if (fields != "") begin
          flag_mismatch($sformatf("wrong%s: want %0d/%0d/%08h/%0d got %0d/%0d/%08h/%0d",
                                  fields, want.kind, want.elem, want.val, want.last,
                                  got.kind, got.elem, got.val, got.last));
        end
      end
    endtask
  endclass

endpackage

// File: dv/tb_embedding_table_sgd_engine_core.sv
// Testbench top: drives items and register writes, checks result beats against the mirror.
module tb_embedding_table_sgd_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import esgd_pkg::*;
  import embed_table_mirror_pkg::*;

  // long enough to span the reset clearing pass over ROWS*DIM entries
  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE_GAP  = 8;
  localparam int HOLD_CYCLES = 400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // [7:0] position, [39:8] token_id, [43:40] element, [75:44] value
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  // [1:0] cmd
  logic [CMD_W-1:0]       s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // [3:0] out_element, [35:4] out_value
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // [0] out_kind
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_index_i;
  logic [LR_W-1:0]        cfg_data_i;

  embed_table_mirror sb;
  int                idle_pct;
  int                stall_pct;
  int                hold_left;
  int                quiet_cycles;
  logic [POS_W-1:0]  seen_slots[$];
  bit                slot_seen [SLOTS];
  int                filled_rows[$];
  bit                row_filled [ROWS];

  embedding_table_sgd_engine_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: every handshake at this edge goes to the scoreboard
  always @(posedge clk_i) begin
    beat_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.absorb_item(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[7:0], s_axis_tdata_i[39:8],
                       s_axis_tdata_i[43:40], s_axis_tdata_i[75:44]);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind = m_axis_tuser_o;
        got.elem = m_axis_tdata_o[3:0];
        got.val  = m_axis_tdata_o[35:4];
        got.last = m_axis_tlast_o;
        sb.check_beat(got);
      end
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin
    quiet_cycles = 0;
    @(posedge clk_i);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Watchdog: no beat for %0d cycles, %0d beats still due",
             STALL_LIMIT, sb.pending_beats.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(20'hfffff));
      3: return -32'($urandom_range(20'hfffff));
      default: return $urandom;
    endcase
  endfunction

  // Any fully loaded row below the active count; row 0 is always loaded
  function automatic int pick_row(int n);
    int r;
    do r = filled_rows[$urandom_range(filled_rows.size() - 1)]; while (r >= n);
    return r;
  endfunction

  // Raw id that lands on row r, often from beyond the clamp limits
  function automatic logic [31:0] lookup_token(int r, int n);
    logic [31:0] raw;
    raw = 32'(r);
    if (r == 0 && $urandom_range(1) == 1) begin
      raw = {1'b1, 31'($urandom)};
    end else if (r == n - 1 && $urandom_range(1) == 1) begin
      raw = {1'b0, 31'($urandom)};
      if (raw < 32'(n)) raw = 32'(n);
    end
    return raw;
  endfunction

  // Offer one item; valid stays high after the beat unless the next one idles
  task automatic send_item(cmd_e cmd, logic [POS_W-1:0] pos, logic [31:0] tok,
                           logic [ELEM_W-1:0] elem, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, val, elem, tok, pos};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cmd == CMD_LOOKUP && !slot_seen[pos]) begin
      slot_seen[pos] = 1'b1;
      seen_slots.push_back(pos);
    end
  endtask

  // Stop offering and wait until every expected beat is out, then let loads settle
  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [LR_W-1:0] lr, logic [VC_W-1:0] vc);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LR;
    cfg_data_i  <= lr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_VC;
    cfg_data_i  <= LR_W'(vc);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic fill_row(int r, logic [31:0] raw);
    for (int e = 0; e < DIM; e++) begin
      send_item(CMD_LOAD, POS_W'($urandom), raw, ELEM_W'(e), rand_word());
    end
    if (!row_filled[r]) begin
      row_filled[r] = 1'b1;
      filled_rows.push_back(r);
    end
  endtask

  task automatic random_item(int n);
    int pick;
    int r;
    pick = $urandom_range(99);
    if (pick < 20 && n <= DIM) begin
      send_item(CMD_UPDATE, POS_W'($urandom), $urandom, ELEM_W'($urandom), $urandom);
    end else if (pick < 50 && seen_slots.size() > 0) begin
      send_item(CMD_GRAD, seen_slots[$urandom_range(seen_slots.size() - 1)], $urandom,
                ELEM_W'($urandom), rand_word());
    end else if (pick < 70) begin
      send_item(CMD_LOAD, POS_W'($urandom),
                ($urandom_range(1) == 1) ? 32'(pick_row(n)) : $urandom,
                ELEM_W'($urandom), rand_word());
    end else begin
      r = pick_row(n);
      send_item(CMD_LOOKUP, POS_W'($urandom), lookup_token(r, n), ELEM_W'($urandom), $urandom);
    end
  endtask

  // One random phase: idle profile, register setting, table fill, optional squeeze, then items
  task automatic run_phase(int in_pct, int out_pct, logic [LR_W-1:0] lr, logic [VC_W-1:0] vc,
                           int count, bit squeeze);
    int n;
    settle_block();
    idle_pct  = in_pct;
    stall_pct = out_pct;
    write_regs(lr, vc);
    n = sb.rows_active();
    // updates read every weight in use, so those rows get loaded first
    if (n <= DIM) begin
      for (int r = 0; r < n; r++) if (!row_filled[r]) fill_row(r, 32'(r));
    end
    if (squeeze) begin
      hold_left = HOLD_CYCLES;
      repeat (6) send_item(CMD_LOOKUP, POS_W'($urandom), 32'(pick_row(n)), '0, '0);
    end
    repeat (count) random_item(n);
  endtask

  initial begin
    sb = new();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_LOOKUP;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_LR;
    cfg_data_i      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // registers are taken even while the gradient store is being cleared
    write_regs(LR_W'(65536), VC_W'(1024));

    // Directed: clamping at both ends, saturation of sums and of the step
    fill_row(0, 32'h8000_0000);
    fill_row(1, 32'd1);
    fill_row(ROWS - 1, 32'h7fff_ffff);
    send_item(CMD_LOAD, 8'd9, -32'sd7, 4'd0, 32'h8000_0000);
    send_item(CMD_LOAD, 8'd200, 32'd0, 4'd1, 32'h7fff_ffff);
    send_item(CMD_LOOKUP, 8'd0, 32'h8000_0000, 4'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd255, 32'h7fff_ffff, 4'hf, 32'hffff_ffff);
    send_item(CMD_LOOKUP, 8'd17, 32'd1023, 4'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd18, 32'd1, 4'd0, 32'd0);
    send_item(CMD_GRAD, 8'd0, $urandom, 4'd0, 32'h7fff_ffff);
    send_item(CMD_GRAD, 8'd0, $urandom, 4'd0, 32'h7fff_ffff);
    send_item(CMD_GRAD, 8'd0, $urandom, 4'd1, 32'h8000_0000);
    send_item(CMD_GRAD, 8'd0, $urandom, 4'd1, 32'h8000_0000);
    send_item(CMD_GRAD, 8'd255, $urandom, 4'd15, -32'sd3);
    send_item(CMD_LOOKUP, 8'd17, 32'd1024, 4'd0, 32'd0);
    settle_block();
    write_regs(LR_W'(65536), VC_W'(2));
    send_item(CMD_UPDATE, 8'd0, 32'd0, 4'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd0, 32'd0, 4'd0, 32'd0);
    // slot 255 still holds row 1023, now clamped to the last row in use
    send_item(CMD_GRAD, 8'd255, $urandom, 4'd3, 32'h0001_2345);
    send_item(CMD_LOOKUP, 8'd3, 32'd5000, 4'd0, 32'd0);
    send_item(CMD_UPDATE, 8'd1, 32'd0, 4'd0, 32'd0);
    settle_block();
    write_regs(LR_W'(0), VC_W'(2));
    send_item(CMD_GRAD, 8'd18, $urandom, 4'd7, 32'h0400_0000);
    send_item(CMD_UPDATE, 8'd2, 32'd0, 4'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd4, 32'd1, 4'd0, 32'd0);

    // Random phases over idle profiles and register settings
    run_phase(0, 0, LR_W'(1), VC_W'(2), 10, 1'b1);
    run_phase(47, 0, LR_W'($urandom_range(65536)), VC_W'(1024), 10, 1'b0);
    run_phase(0, 47, LR_W'(65536), VC_W'(0), 10, 1'b0);
    run_phase(21, 21, LR_W'($urandom_range(65536)), VC_W'(2), 10, 1'b0);
    run_phase(0, 0, LR_W'(0), VC_W'(2047), 10, 1'b0);
    run_phase(21, 21, LR_W'($urandom_range(65536)), VC_W'(1), 10, 1'b0);
    settle_block();
    repeat (20) @(posedge clk_i);

    $display("Items: %0d lookups, %0d gradient adds, %0d update walks, %0d weight loads",
             sb.cmd_seen[CMD_LOOKUP], sb.cmd_seen[CMD_GRAD], sb.cmd_seen[CMD_UPDATE],
             sb.cmd_seen[CMD_LOAD]);
    $display("%0d result beats checked over row counts 0..2, 1024, 2047 and step sizes 0..1.0",
             sb.beats_seen);
    if (sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
